>>> src/free_extent_coalescer_defines.svh
// ----------------------------------------------------------------------------
// Free extent coalescer assertion macros
// Shared concurrent assertion forms used by the coalescer top level.
// ----------------------------------------------------------------------------
`ifndef FREE_EXTENT_COALESCER_DEFINES_SVH
`define FREE_EXTENT_COALESCER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FEC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("free_extent_coalescer: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define FEC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("free_extent_coalescer: assertion failed");

`endif

>>> src/fec_pkg.sv
// ----------------------------------------------------------------------------
// Free extent coalescer package
// Types, codes and defaults shared by the coalescer modules.
// ----------------------------------------------------------------------------
package fec_pkg;

    localparam int TABLE_CAPACITY_DEF     = 64;
    localparam int ENTRIES_PER_SECTOR_DEF = 64;

    localparam logic [3:0] ST_ZERO_LEN       = 4'd0;
    localparam logic [3:0] ST_OUT_OF_RANGE   = 4'd1;
    localparam logic [3:0] ST_GREW_PREV      = 4'd2;
    localparam logic [3:0] ST_PREV_FOLLOW    = 4'd3;
    localparam logic [3:0] ST_PREV_OPEN      = 4'd4;
    localparam logic [3:0] ST_OPEN           = 4'd5;
    localparam logic [3:0] ST_FOLLOW         = 4'd6;
    localparam logic [3:0] ST_APPENDED       = 4'd7;
    localparam logic [3:0] ST_TABLE_FULL     = 4'd8;

    localparam logic [1:0] REG_DISK_SECTORS  = 2'd0;
    localparam logic [1:0] REG_FIRST_USABLE  = 2'd1;
    localparam logic [1:0] REG_OPEN_START    = 2'd2;
    localparam logic [1:0] REG_OPEN_LEN      = 2'd3;

    typedef struct packed {
        logic [31:0] start;
        logic [31:0] len;
    } entry_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_ROTATE,
        CELL_WRITE,
        CELL_DROP
    } cell_op_t;

    typedef struct packed {
        cell_op_t    op;
        logic        start_en;
        logic [31:0] wr_start;
        logic [31:0] wr_len;
    } cell_cmd_t;

    typedef struct packed {
        logic [31:0] disk_sectors;
        logic [31:0] first_usable;
    } cfg_t;

    typedef struct packed {
        logic        ld_start;
        logic        ld_len;
        logic [31:0] data;
    } open_load_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN1,
        S_DEC1,
        S_JOIN,
        S_SCAN2,
        S_DEC2,
        S_WRITE,
        S_DROP,
        S_FIN
    } state_t;

endpackage

>>> src/fec_cell.sv
// ----------------------------------------------------------------------------
// Free extent table cell
// Holds one table entry and takes its neighbor's entry on rotate or drop.
// ----------------------------------------------------------------------------
module fec_cell
    import fec_pkg::*;
#(
    parameter int IW       = 6,
    parameter int CELL_IDX = 0
)
(
    input  logic            clk,
    input  cell_cmd_t       cmd,
    input  logic [IW-1:0]   cmd_idx,
    input  entry_t          nbr,
    output entry_t          q
);

    entry_t entry_reg;

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            CELL_ROTATE:
            begin
                entry_reg <= nbr;
            end
            CELL_WRITE:
            begin
                if (cmd_idx == IW'(CELL_IDX))
                begin
                    if (cmd.start_en)
                    begin
                        entry_reg.start <= cmd.wr_start;
                    end
                    entry_reg.len <= cmd.wr_len;
                end
            end
            CELL_DROP:
            begin
                if (IW'(CELL_IDX) >= cmd_idx)
                begin
                    entry_reg <= nbr;
                end
            end
            default:
            begin
                entry_reg <= entry_reg;
            end
        endcase
    end

    assign q = entry_reg;

endmodule

>>> src/fec_cfg.sv
// ----------------------------------------------------------------------------
// Free extent coalescer configuration registers
// APB-style register file with open region load strobes.
// ----------------------------------------------------------------------------
module fec_cfg
    import fec_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg,
    output open_load_t  open_load
);

    logic [31:0] disk_reg;
    logic [31:0] first_reg;
    logic [31:0] ostart_reg;
    logic [31:0] olen_reg;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            disk_reg   <= '0;
            first_reg  <= '0;
            ostart_reg <= '0;
            olen_reg   <= '0;
        end
        else if (wr_en)
        begin
            unique case (paddr[3:2])
                REG_DISK_SECTORS: disk_reg   <= pwdata;
                REG_FIRST_USABLE: first_reg  <= pwdata;
                REG_OPEN_START:   ostart_reg <= pwdata;
                REG_OPEN_LEN:     olen_reg   <= pwdata;
                default:          disk_reg   <= disk_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_DISK_SECTORS: prdata = disk_reg;
            REG_FIRST_USABLE: prdata = first_reg;
            REG_OPEN_START:   prdata = ostart_reg;
            REG_OPEN_LEN:     prdata = olen_reg;
            default:          prdata = '0;
        endcase
    end

    assign cfg.disk_sectors = disk_reg;
    assign cfg.first_usable = first_reg;

    assign open_load.ld_start = wr_en && (paddr[3:2] == REG_OPEN_START);
    assign open_load.ld_len   = wr_en && (paddr[3:2] == REG_OPEN_LEN);
    assign open_load.data     = pwdata;

endmodule

>>> src/free_extent_coalescer.sv
// ----------------------------------------------------------------------------
// Free extent coalescer
// Merges freed extents into a table of free extents and one open region.
// ----------------------------------------------------------------------------
// A rejected word (zero length or out of range) goes from acceptance
// straight to the finish state, which loads its result into the output
// register. A word that joins the open region with no preceding entry, and a
// word that grows a preceding entry which then joins the open region, each
// take one rotation of the ring of entry cells past the compare logic at its
// head. Any other word takes two full rotations of the ring, then a write, a
// drop or both where the table changes. A result that cannot leave the output
// register delays the result of the next word by the same stall. One word is
// worked on at a time; a finished result waits in the output register while
// the next word is taken.
// ----------------------------------------------------------------------------
`include "free_extent_coalescer_defines.svh"

module free_extent_coalescer
    import fec_pkg::*;
#(
    parameter int TABLE_CAPACITY     = TABLE_CAPACITY_DEF,
    parameter int ENTRIES_PER_SECTOR = ENTRIES_PER_SECTOR_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] start_sector,
    input  logic [31:0] sector_count,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  status,
    output logic [6:0]  entry_count,
    output logic [31:0] open_start,
    output logic [31:0] open_len
);

    localparam int IW = $clog2(TABLE_CAPACITY);
    localparam int CW = $clog2(TABLE_CAPACITY + 1);
    localparam int FW = (ENTRIES_PER_SECTOR > 1) ? $clog2(ENTRIES_PER_SECTOR) : 1;

    cfg_t        cfg;
    open_load_t  open_load;
    cell_cmd_t   cmd;
    logic [IW-1:0] cmd_idx;
    entry_t      cells [TABLE_CAPACITY];
    entry_t      head;

    state_t      state_reg, state_next;

    logic [31:0] lba_reg, cnt_reg;
    logic [31:0] open_start_reg, open_len_reg;
    logic [CW-1:0] total_reg;
    logic [CW-1:0] rsv_reg;
    logic [FW-1:0] frac_reg;
    logic [IW-1:0] ptr_reg;
    logic [IW-1:0] m_reg, k_reg, drop_idx_reg, wr_idx_reg;
    logic        f1_reg, f2_reg, drop_after_reg, app_reg;
    logic [31:0] cap_s_reg, cap_l_reg, cap2_l_reg, nl_reg, key_reg;
    logic [31:0] wr_s_reg, wr_l_reg;
    logic        wr_s_en_reg;
    logic [3:0]  st_reg;

    logic        out_valid_reg;
    logic [3:0]  out_status_reg;
    logic [6:0]  out_count_reg;
    logic [31:0] out_ostart_reg, out_olen_reg;

    logic        accept;
    logic        oor;
    logic        scan_last;
    logic        in_tab;
    logic        hit1, hit2;
    logic [31:0] end_w, key_w;
    logic        fin_load;

    fec_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .cfg       (cfg),
        .open_load (open_load)
    );

    for (genvar i = 0; i < TABLE_CAPACITY; i++)
    begin : g_cell
        fec_cell #(
            .IW       (IW),
            .CELL_IDX (i)
        ) u_cell (
            .clk     (clk),
            .cmd     (cmd),
            .cmd_idx (cmd_idx),
            .nbr     (cells[(i + 1) % TABLE_CAPACITY]),
            .q       (cells[i])
        );
    end

    assign head = cells[0];

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign oor       = (start_sector < cfg.first_usable) ||
                       (({1'b0, start_sector} + 33'(rsv_reg) + 33'd1) >
                        {1'b0, cfg.disk_sectors});
    assign scan_last = (ptr_reg == IW'(TABLE_CAPACITY - 1));
    assign in_tab    = (CW'(ptr_reg) < total_reg);
    assign hit1      = in_tab && !f1_reg && ((head.start + head.len) == lba_reg);
    assign hit2      = in_tab && !f2_reg && (head.start == key_reg);
    assign end_w     = lba_reg + cnt_reg;
    assign key_w     = cap_s_reg + nl_reg;
    assign fin_load  = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (sector_count == '0 || oor)
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        state_next = S_SCAN1;
                    end
                end
            end
            S_SCAN1:
            begin
                if (scan_last)
                begin
                    state_next = S_DEC1;
                end
            end
            S_DEC1:
            begin
                if (f1_reg)
                begin
                    state_next = S_JOIN;
                end
                else if (end_w == open_start_reg)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_SCAN2;
                end
            end
            S_JOIN:
            begin
                if (key_w == open_start_reg)
                begin
                    state_next = S_DROP;
                end
                else
                begin
                    state_next = S_SCAN2;
                end
            end
            S_SCAN2:
            begin
                if (scan_last)
                begin
                    state_next = S_DEC2;
                end
            end
            S_DEC2:
            begin
                if (f1_reg && f2_reg && (k_reg == m_reg))
                begin
                    state_next = S_DROP;
                end
                else if (!f1_reg && !f2_reg && (total_reg >= CW'(TABLE_CAPACITY)))
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                state_next = drop_after_reg ? S_DROP : S_FIN;
            end
            S_DROP:
            begin
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (fin_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd.op       = CELL_HOLD;
        cmd.start_en = wr_s_en_reg;
        cmd.wr_start = wr_s_reg;
        cmd.wr_len   = wr_l_reg;
        cmd_idx      = wr_idx_reg;
        unique case (state_reg)
            S_SCAN1, S_SCAN2:
            begin
                cmd.op = CELL_ROTATE;
            end
            S_WRITE:
            begin
                cmd.op = CELL_WRITE;
            end
            S_DROP:
            begin
                cmd.op  = CELL_DROP;
                cmd_idx = drop_idx_reg;
            end
            default:
            begin
                cmd.op = CELL_HOLD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            total_reg      <= '0;
            rsv_reg        <= '0;
            frac_reg       <= '0;
            open_start_reg <= '0;
            open_len_reg   <= '0;
            ptr_reg        <= '0;
            f1_reg         <= 1'b0;
            f2_reg         <= 1'b0;
            drop_after_reg <= 1'b0;
            app_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (open_load.ld_start)
            begin
                open_start_reg <= open_load.data;
            end
            if (open_load.ld_len)
            begin
                open_len_reg <= open_load.data;
            end
            if (state_reg == S_FIN && fin_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    ptr_reg        <= '0;
                    f1_reg         <= 1'b0;
                    f2_reg         <= 1'b0;
                    drop_after_reg <= 1'b0;
                    app_reg        <= 1'b0;
                    if (accept)
                    begin
                        lba_reg <= start_sector;
                        cnt_reg <= sector_count;
                        if (sector_count == '0)
                        begin
                            st_reg <= ST_ZERO_LEN;
                        end
                        else
                        begin
                            st_reg <= ST_OUT_OF_RANGE;
                        end
                    end
                end
                S_SCAN1:
                begin
                    ptr_reg <= ptr_reg + 1'b1;
                    if (hit1)
                    begin
                        f1_reg    <= 1'b1;
                        m_reg     <= ptr_reg;
                        cap_s_reg <= head.start;
                        cap_l_reg <= head.len;
                    end
                end
                S_DEC1:
                begin
                    ptr_reg <= '0;
                    nl_reg  <= cap_l_reg + cnt_reg;
                    key_reg <= end_w;
                    if (!f1_reg && (end_w == open_start_reg))
                    begin
                        st_reg         <= ST_OPEN;
                        open_start_reg <= lba_reg;
                        open_len_reg   <= open_len_reg + cnt_reg;
                    end
                end
                S_JOIN:
                begin
                    key_reg <= key_w;
                    if (key_w == open_start_reg)
                    begin
                        st_reg         <= ST_PREV_OPEN;
                        open_start_reg <= cap_s_reg;
                        open_len_reg   <= open_len_reg + nl_reg;
                        drop_idx_reg   <= m_reg;
                    end
                end
                S_SCAN2:
                begin
                    ptr_reg <= ptr_reg + 1'b1;
                    if (hit2)
                    begin
                        f2_reg     <= 1'b1;
                        k_reg      <= ptr_reg;
                        cap2_l_reg <= head.len;
                    end
                end
                S_DEC2:
                begin
                    drop_idx_reg <= k_reg;
                    if (f1_reg)
                    begin
                        wr_idx_reg  <= m_reg;
                        wr_s_en_reg <= 1'b0;
                        wr_s_reg    <= cap_s_reg;
                        if (f2_reg)
                        begin
                            st_reg         <= ST_PREV_FOLLOW;
                            wr_l_reg       <= nl_reg + cap2_l_reg;
                            drop_after_reg <= 1'b1;
                        end
                        else
                        begin
                            st_reg   <= ST_GREW_PREV;
                            wr_l_reg <= nl_reg;
                        end
                    end
                    else if (f2_reg)
                    begin
                        st_reg      <= ST_FOLLOW;
                        wr_idx_reg  <= k_reg;
                        wr_s_en_reg <= 1'b1;
                        wr_s_reg    <= lba_reg;
                        wr_l_reg    <= cap2_l_reg + cnt_reg;
                    end
                    else if (total_reg >= CW'(TABLE_CAPACITY))
                    begin
                        st_reg <= ST_TABLE_FULL;
                    end
                    else
                    begin
                        st_reg      <= ST_APPENDED;
                        app_reg     <= 1'b1;
                        wr_idx_reg  <= IW'(total_reg);
                        wr_s_en_reg <= 1'b1;
                        wr_s_reg    <= lba_reg;
                        wr_l_reg    <= cnt_reg;
                    end
                end
                S_WRITE:
                begin
                    if (app_reg)
                    begin
                        total_reg <= total_reg + 1'b1;
                        if (frac_reg == '0)
                        begin
                            rsv_reg <= rsv_reg + 1'b1;
                        end
                        if (frac_reg == FW'(ENTRIES_PER_SECTOR - 1))
                        begin
                            frac_reg <= '0;
                        end
                        else
                        begin
                            frac_reg <= frac_reg + 1'b1;
                        end
                    end
                end
                S_DROP:
                begin
                    total_reg <= total_reg - 1'b1;
                    if (frac_reg == '0)
                    begin
                        frac_reg <= FW'(ENTRIES_PER_SECTOR - 1);
                        if (FW'(ENTRIES_PER_SECTOR - 1) == '0)
                        begin
                            rsv_reg <= rsv_reg - 1'b1;
                        end
                    end
                    else
                    begin
                        frac_reg <= frac_reg - 1'b1;
                        if (frac_reg == FW'(1))
                        begin
                            rsv_reg <= rsv_reg - 1'b1;
                        end
                    end
                end
                default:
                begin
                    ptr_reg <= '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_FIN && fin_load)
        begin
            out_status_reg <= st_reg;
            out_count_reg  <= 7'(total_reg);
            out_ostart_reg <= open_start_reg;
            out_olen_reg   <= open_len_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign entry_count = out_count_reg;
    assign open_start  = out_ostart_reg;
    assign open_len    = out_olen_reg;

    `FEC_ASSERT_NOW(a_total_bound, clk, rst_n, 1'b1, total_reg <= CW'(TABLE_CAPACITY))
    `FEC_ASSERT_NOW(a_drop_nonempty, clk, rst_n, state_reg == S_DROP, total_reg != '0)
    `FEC_ASSERT_NOW(a_rsv_zero, clk, rst_n, 1'b1, (total_reg == '0) == (rsv_reg == '0))
    `FEC_ASSERT_NOW(a_status_code, clk, rst_n, out_valid_reg, out_status_reg <= ST_TABLE_FULL)

endmodule
